/* design/grid_path_count_obstacles_defines.svh */
// assertion macros shared by the grid path counter checker
// no dependencies; included by the checker file
`ifndef GRID_PATH_COUNT_OBSTACLES_DEFINES_SVH
`define GRID_PATH_COUNT_OBSTACLES_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GPCO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define GPCO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gpco_pkg.sv */
// shared constants and register codes for the grid path counter
// no dependencies; used by the interfaces, the top level and the checker
package gpco_pkg;

    // parameter defaults
    localparam int MAX_COLS_DEF    = 128;
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed field widths
    localparam int PATH_W = 32;
    localparam int COLS_W = 8;
    localparam int ROWS_W = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_GRID_COLS = 1'b0;
    localparam logic REG_GRID_ROWS = 1'b1;

    localparam logic [COLS_W-1:0] GRID_COLS_RST = COLS_W'(1);
    localparam logic [ROWS_W-1:0] GRID_ROWS_RST = ROWS_W'(1);

endpackage

/* design/gpco_if.sv */
// valid/ready channels of the grid path counter: cell beats in, result beats out
// depends on gpco_pkg for the count width
interface gpco_cell_if;
    logic valid;
    logic ready;
    logic cell_blocked;

    modport source (output valid, output cell_blocked, input ready);
    modport sink (input valid, input cell_blocked, output ready);
endinterface

interface gpco_result_if;
    logic                        valid;
    logic                        ready;
    logic [gpco_pkg::PATH_W-1:0] path_count;
    logic                        count_saturated;
    logic                        grid_done;

    modport source (output valid, output path_count, output count_saturated,
                    output grid_done, input ready);
    modport sink (input valid, input path_count, input count_saturated,
                  input grid_done, output ready);
endinterface

/* design/grid_path_count_obstacles.sv */
// Grid path counter with obstacles. Cells stream in row-major order, one beat per cell, and
// every cell gives one result beat with its saturated count of right/down paths from the
// top-left cell; the bottom-right cell carries grid_done. The block takes one cell per clock
// when the result side keeps up; an accepted cell enters stage 1, and its result moves to
// the output register when stage 1 advances. The rate is set by the row store, a memory
// with one read and one write port: each cell reads its column in the accept cycle and
// writes it back when stage 1 advances, with forwarding when the next cell reads the
// column just written (one-column grids). Writing grid_cols or grid_rows restarts the grid
// at the top-left cell; write them only while no result is outstanding.
// depends on gpco_pkg and the channel interfaces in gpco_if.sv
module grid_path_count_obstacles #(
    parameter int MAX_COLS    = gpco_pkg::MAX_COLS_DEF,
    parameter int COUNT_WIDTH = gpco_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gpco_cell_if.sink                       cells,
    gpco_result_if.source                   results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gpco_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gpco_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gpco_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CMP_W = (AW + 1 > gpco_pkg::COLS_W) ? AW + 1 : gpco_pkg::COLS_W;
    localparam int RW    = gpco_pkg::ROWS_W;
    localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] ONE_C      = CMP_W'(1);

    typedef struct packed {
        logic [AW-1:0] col;
        logic          first_row;
        logic          col0;
        logic          blocked;
        logic          grid_end;
        logic          fwd;
    } s1_t;

    // configuration registers
    logic [gpco_pkg::COLS_W-1:0] grid_cols_reg, grid_cols_next;
    logic [RW-1:0]               grid_rows_reg, grid_rows_next;
    logic                        cfg_wr;

    // position counters
    logic [AW-1:0] col_idx_reg, col_idx_next;
    logic [RW-1:0] row_idx_reg, row_idx_next;

    // stage 1 and output register
    logic                   s1_valid_reg, s1_valid_next;
    s1_t                    s1_reg, s1_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic [COUNT_WIDTH-1:0] fwd_data_reg, fwd_data_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_count_reg, out_count_next;
    logic                   out_sat_reg, out_sat_next;
    logic                   out_done_reg, out_done_next;

    // row store
    logic [COUNT_WIDTH-1:0] row_mem [MAX_COLS];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    logic                   accept;
    logic                   s1_adv;
    logic [CMP_W-1:0]       eff_cols;
    logic [RW-1:0]          eff_rows;
    logic                   row_end;
    logic                   grid_end;
    logic [COUNT_WIDTH-1:0] above;
    logic [COUNT_WIDTH-1:0] left_val;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] count;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            gpco_pkg::REG_GRID_COLS: prdata = gpco_pkg::APB_DATA_W'(grid_cols_reg);
            gpco_pkg::REG_GRID_ROWS: prdata = gpco_pkg::APB_DATA_W'(grid_rows_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        grid_cols_next = grid_cols_reg;
        grid_rows_next = grid_rows_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                gpco_pkg::REG_GRID_COLS: grid_cols_next = pwdata[gpco_pkg::COLS_W-1:0];
                gpco_pkg::REG_GRID_ROWS: grid_rows_next = pwdata[RW-1:0];
                default:                 grid_cols_next = grid_cols_reg;
            endcase
        end
    end

    // effective grid size
    always_comb
    begin
        if (grid_cols_reg == '0)
            eff_cols = ONE_C;
        else if (CMP_W'(grid_cols_reg) > MAX_COLS_C)
            eff_cols = MAX_COLS_C;
        else
            eff_cols = CMP_W'(grid_cols_reg);
        eff_rows = (grid_rows_reg == '0) ? RW'(1) : grid_rows_reg;
    end

    // handshake
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign cells.ready  = !s1_valid_reg || s1_adv;
    assign accept       = cells.valid && cells.ready;

    assign row_end  = (CMP_W'(col_idx_reg) + ONE_C) >= eff_cols;
    assign grid_end = row_end && (({1'b0, row_idx_reg} + (RW + 1)'(1)) >= {1'b0, eff_rows});

    // position counters, restarted by any config write
    always_comb
    begin
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        if (cfg_wr)
        begin
            col_idx_next = '0;
            row_idx_next = '0;
        end
        else if (accept)
        begin
            if (grid_end)
            begin
                col_idx_next = '0;
                row_idx_next = '0;
            end
            else if (row_end)
            begin
                col_idx_next = '0;
                row_idx_next = row_idx_reg + RW'(1);
            end
            else
            begin
                col_idx_next = col_idx_reg + AW'(1);
            end
        end
    end

    // stage 1 capture; forward when the column is written in the read cycle
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (accept)
        begin
            s1_valid_next     = 1'b1;
            s1_next.col       = col_idx_reg;
            s1_next.first_row = (row_idx_reg == '0);
            s1_next.col0      = (col_idx_reg == '0);
            s1_next.blocked   = cells.cell_blocked;
            s1_next.grid_end  = grid_end;
            s1_next.fwd       = s1_adv && (s1_reg.col == col_idx_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // count of the stage 1 cell
    always_comb
    begin
        if (s1_reg.first_row)
            above = s1_reg.col0 ? COUNT_WIDTH'(1) : '0;
        else if (s1_reg.fwd)
            above = fwd_data_reg;
        else
            above = rd_data_reg;
        left_val = s1_reg.col0 ? '0 : left_reg;
        sum      = {1'b0, above} + {1'b0, left_val};
        if (s1_reg.blocked)
            count = '0;
        else if (sum[COUNT_WIDTH])
            count = '1;
        else
            count = sum[COUNT_WIDTH-1:0];
    end

    always_comb
    begin
        left_next     = s1_adv ? count : left_reg;
        fwd_data_next = s1_adv ? count : fwd_data_reg;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_sat_next   = out_sat_reg;
        out_done_next  = out_done_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            out_count_next = count;
            out_sat_next   = (count == '1);
            out_done_next  = s1_reg.grid_end;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.path_count      = gpco_pkg::PATH_W'(out_count_reg);
    assign results.count_saturated = out_sat_reg;
    assign results.grid_done       = out_done_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= gpco_pkg::GRID_COLS_RST;
            grid_rows_reg <= gpco_pkg::GRID_ROWS_RST;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            grid_cols_reg <= grid_cols_next;
            grid_rows_reg <= grid_rows_next;
            col_idx_reg   <= col_idx_next;
            row_idx_reg   <= row_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        fwd_data_reg  <= fwd_data_next;
        out_count_reg <= out_count_next;
        out_sat_reg   <= out_sat_next;
        out_done_reg  <= out_done_next;
    end

    // row store: write back from stage 1, read at accept
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            row_mem[s1_reg.col] <= count;
        if (accept)
            rd_data_reg <= row_mem[col_idx_reg];
    end

endmodule

/* design/gpco_checker.sv */
// port-level checks for the grid path counter, bound to the top level
// depends on gpco_pkg, gpco_if.sv and grid_path_count_obstacles_defines.svh
`include "grid_path_count_obstacles_defines.svh"

module gpco_checker #(
    parameter int COUNT_WIDTH = gpco_pkg::COUNT_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [gpco_pkg::PATH_W-1:0]     res_count,
    input logic                            res_sat,
    input logic                            res_done,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic                            pready,
    input logic [gpco_pkg::APB_ADDR_W-1:0] paddr,
    input logic [gpco_pkg::APB_DATA_W-1:0] pwdata,
    input logic [gpco_pkg::APB_DATA_W-1:0] prdata
);

    localparam logic [gpco_pkg::PATH_W-1:0] SAT_LOW =
        gpco_pkg::PATH_W'({COUNT_WIDTH{1'b1}});

    // a stalled result beat stays offered
    `GPCO_ASSERT_NEXT(a_res_valid_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result beat dropped while stalled")

    // a stalled result beat keeps its payload
    `GPCO_ASSERT_NEXT(a_res_payload_hold, clk, rst_n, res_valid && !res_ready, $stable(res_count) && $stable(res_sat) && $stable(res_done), "result payload changed while stalled")

    // saturation flag only with a saturated count
    `GPCO_ASSERT_IMPL(a_sat_count, clk, rst_n, res_valid && res_sat, res_count == SAT_LOW, "saturation flag without saturated count")

    // column register reads back what was written
    `GPCO_ASSERT_NEXT(a_cols_readback, clk, rst_n, psel && penable && pwrite && pready && (paddr[2] == gpco_pkg::REG_GRID_COLS), (paddr[2] != gpco_pkg::REG_GRID_COLS) || (prdata[gpco_pkg::COLS_W-1:0] == $past(pwdata[gpco_pkg::COLS_W-1:0])), "grid_cols readback mismatch")

endmodule

bind grid_path_count_obstacles gpco_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_gpco_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_count (results.path_count),
    .res_sat   (results.count_saturated),
    .res_done  (results.grid_done),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
